// File: sv/scope_trigger_trace_rasterizer_core_assert.svh
// Assertion macros for the trace rasterizer checker.
`ifndef SCOPE_TRIGGER_TRACE_RASTERIZER_CORE_ASSERT_SVH
`define SCOPE_TRIGGER_TRACE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define STTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define STTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sttr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sttr_pkg;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int GAIN_W   = 8;
    localparam int LEVEL_W  = 6;
    localparam int PAGE_W   = 3;
    localparam int POS_W    = 3;
    localparam int ADDR_W   = 6;
    localparam int COL_W    = 7;
    localparam int BYTE_W   = 8;

    // level0 = floor(sample * 0.196) as (sample * 12846) >> 16, exact for 8-bit samples
    localparam int                 SCALE_SHIFT = 16;
    localparam int                 PROD_W      = SCALE_SHIFT + LEVEL_W;
    localparam logic [PROD_W-1:0]  SCALE_MUL   = 22'd12846;

    // Trigger levels
    localparam logic [SAMPLE_W-1:0] TRIG_A = 8'd128;
    localparam logic [SAMPLE_W-1:0] TRIG_B = 8'd129;
    localparam logic [SAMPLE_W-1:0] TRIG_C = 8'd130;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd1;
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 8'd1;

    localparam logic [PAGE_W-1:0] PAGE_LAST = 3'd7;
    localparam logic [POS_W-1:0]  POS_TOP   = 3'd7;
    localparam logic [POS_W-1:0]  POS_BOT   = 3'd0;

    // Display bytes
    localparam logic [BYTE_W-1:0] BYTE_CLEAR = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'hff;
    localparam logic [BYTE_W-1:0] BYTE_BIT7  = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_BIT0  = 8'h01;

    // Controller to datapath
    typedef struct packed {
        logic              start;
        logic              emit_clear;
        logic              emit_trace;
        logic              commit;
        logic [COL_W-1:0]  col;
        logic [PAGE_W-1:0] clr_page;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic div_done;
        logic trace_last;
    } t_stat;

endpackage

`default_nettype wire

// File: sv/sttr_channels_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface sttr_sample_if;
    import sttr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// LCD write channel
interface sttr_write_if;
    import sttr_pkg::*;

    logic              valid;
    logic              ready;
    logic              chip_half;
    logic [PAGE_W-1:0] page_row;
    logic [ADDR_W-1:0] column_addr;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_write;

    modport source (
        output valid, output chip_half, output page_row, output column_addr,
        output pixel_byte, output last_write, input ready
    );
    modport sink (
        input valid, input chip_half, input page_row, input column_addr,
        input pixel_byte, input last_write, output ready
    );
endinterface

`default_nettype wire

// File: sv/sttr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sttr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sttr_pkg::LEVEL_W-1:0]   i_dividend,
    input  logic [sttr_pkg::GAIN_W-1:0]    i_divisor,
    output logic [sttr_pkg::LEVEL_W-1:0]   o_quotient,
    output logic                           o_done
);
    import sttr_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEVEL_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [GAIN_W-1:0]  r_rem;
    logic [LEVEL_W-1:0] r_quo;

    logic [GAIN_W:0]    w_trial;
    logic [GAIN_W:0]    w_diff;
    logic               w_fit;

    // trial subtract
    always_comb begin
        w_trial = {r_rem, r_quo[LEVEL_W-1]};
        w_fit   = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[GAIN_W-1:0] : w_trial[GAIN_W-1:0];
            r_quo <= {r_quo[LEVEL_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// File: sv/sttr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Trigger phases and write sequencing.
module sttr_ctrl #(
    parameter int TRACE_COLUMNS = 94
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sttr_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_in_ready,
    input  sttr_pkg::t_stat               i_stat,
    output sttr_pkg::t_cmd                o_cmd
);
    import sttr_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(TRACE_COLUMNS - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLEAR = 3'b010,
        S_TRACE = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_SWEEP   = 2'd2
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_trig,  n_trig;
    logic [COL_W-1:0]    r_col,   n_col;
    logic [PAGE_W-1:0]   r_cnt,   n_cnt;
    logic                w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_trig  = r_trig;
        n_col   = r_col;
        n_cnt   = r_cnt;
        o_cmd          = '0;
        o_cmd.col      = r_col;
        o_cmd.clr_page = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (r_phase)
                        PH_CONFIRM: begin
                            if (r_trig > i_sample) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_phase = PH_SWEEP;
                                n_col   = '0;
                            end
                        end
                        PH_SWEEP: begin
                            o_cmd.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            n_phase = PH_HUNT;
                            if (i_sample == TRIG_A || i_sample == TRIG_B ||
                                i_sample == TRIG_C) begin
                                n_trig  = i_sample;
                                n_phase = PH_CONFIRM;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_clear = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == PAGE_LAST) begin
                        n_state = S_TRACE;
                    end
                end
            end
            S_TRACE: begin
                if (i_stat.slot_free && i_stat.div_done) begin
                    o_cmd.emit_trace = 1'b1;
                    if (i_stat.trace_last) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                        if (r_col == LAST_COL) begin
                            n_phase = PH_HUNT;
                            n_col   = '0;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HUNT;
            r_trig  <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_trig  <= n_trig;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: sv/sttr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Level scaling, divider, trace byte generation and output beat register.
module sttr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sttr_pkg::GAIN_W-1:0]   i_cfg_wr_data,
    input  logic [sttr_pkg::SAMPLE_W-1:0] i_sample,
    input  sttr_pkg::t_cmd                i_cmd,
    output sttr_pkg::t_stat               o_stat,
    sttr_write_if.source                  o_wr
);
    import sttr_pkg::*;

    // bits lo..hi set
    function automatic logic [BYTE_W-1:0] f_span(
        input logic [POS_W-1:0] lo,
        input logic [POS_W-1:0] hi
    );
        logic [BYTE_W-1:0] m;
        for (int i = 0; i < BYTE_W; i++) begin
            m[i] = (i >= int'(lo)) && (i <= int'(hi));
        end
        return m;
    endfunction

    logic [GAIN_W-1:0]  r_gain;
    logic [GAIN_W-1:0]  w_divisor;
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0] r_scaled;
    logic               r_div_go;
    logic [LEVEL_W-1:0] w_level;
    logic               w_div_done;

    logic [PAGE_W-1:0]  r_prev_page;
    logic [POS_W-1:0]   r_prev_pos;
    logic [PAGE_W-1:0]  r_k;

    logic [PAGE_W-1:0]  w_page;
    logic [POS_W-1:0]   w_pos;
    logic               w_first;
    logic               w_up;
    logic               w_down;
    logic [PAGE_W-1:0]  w_dist;
    logic               w_last;
    logic [PAGE_W-1:0]  w_row;
    logic [BYTE_W-1:0]  w_byte;

    logic               r_valid;
    logic               r_chip;
    logic [PAGE_W-1:0]  r_page;
    logic [ADDR_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    logic               w_slot_free;

    // gain register, zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end
    assign w_divisor = (r_gain == '0) ? GAIN_MIN : r_gain;

    // sample * 0.196, registered before the divider
    assign w_prod = PROD_W'(i_sample) * SCALE_MUL;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scaled <= w_prod[SCALE_SHIFT +: LEVEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= i_cmd.start;
        end
    end

    sttr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_scaled),
        .i_divisor  (w_divisor),
        .o_quotient (w_level),
        .o_done     (w_div_done)
    );

    // point position and trace write sequence
    always_comb begin
        w_page  = PAGE_LAST - w_level[LEVEL_W-1 -: PAGE_W];
        w_pos   = POS_TOP - w_level[POS_W-1:0];
        w_first = (i_cmd.col == '0);
        w_up    = !w_first && (w_page < r_prev_page);
        w_down  = !w_first && (w_page > r_prev_page);
        if (w_up) begin
            w_dist = r_prev_page - w_page;
            w_row  = w_page + r_k;
        end else if (w_down) begin
            w_dist = w_page - r_prev_page;
            w_row  = w_page - r_k;
        end else begin
            w_dist = '0;
            w_row  = w_page;
        end
        w_last = (r_k == w_dist);

        if (!w_up && !w_down) begin
            // single write on the point page
            if (w_first || (w_pos == r_prev_pos)) begin
                w_byte = f_span(w_pos, w_pos);
            end else if (w_pos > r_prev_pos) begin
                w_byte = f_span(r_prev_pos + 1'b1, w_pos);
            end else begin
                w_byte = f_span(w_pos, r_prev_pos - 1'b1);
            end
        end else if (r_k == '0) begin
            w_byte = w_up ? f_span(w_pos, POS_TOP) : f_span(POS_BOT, w_pos);
        end else if (w_last) begin
            // previous page, filled back to the previous point
            if (w_up) begin
                w_byte = (r_prev_pos == POS_BOT) ? BYTE_BIT0
                                                 : f_span(POS_BOT, r_prev_pos - 1'b1);
            end else begin
                w_byte = (r_prev_pos == POS_TOP) ? BYTE_BIT7
                                                 : f_span(r_prev_pos + 1'b1, POS_TOP);
            end
        end else begin
            w_byte = BYTE_FULL;
        end
    end

    // trace step counter and previous point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_prev_page <= '0;
            r_prev_pos  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_k <= '0;
            end else if (i_cmd.emit_trace) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.commit) begin
                r_prev_page <= w_page;
                r_prev_pos  <= w_pos;
            end
        end
    end

    // output beat register
    assign w_slot_free = !r_valid || o_wr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_clear || i_cmd.emit_trace) begin
            r_valid <= 1'b1;
        end else if (o_wr.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_clear || i_cmd.emit_trace) begin
            r_chip <= i_cmd.col[COL_W-1];
            r_addr <= i_cmd.col[ADDR_W-1:0];
            r_page <= i_cmd.emit_trace ? w_row : i_cmd.clr_page;
            r_byte <= i_cmd.emit_trace ? w_byte : BYTE_CLEAR;
            r_last <= i_cmd.emit_trace && w_last;
        end
    end

    assign o_wr.valid       = r_valid;
    assign o_wr.chip_half   = r_chip;
    assign o_wr.page_row    = r_page;
    assign o_wr.column_addr = r_addr;
    assign o_wr.pixel_byte  = r_byte;
    assign o_wr.last_write  = r_last;

    assign o_stat.slot_free  = w_slot_free;
    assign o_stat.div_done   = w_div_done && !r_div_go;
    assign o_stat.trace_last = w_last;

endmodule

`default_nettype wire

// File: sv/scope_trigger_trace_rasterizer_core.sv
// Hunt and confirm samples: no writes.
// Sweep samples: 8 page clears then 1 to 7 point writes, one beat per cycle through the
// output register while the receiver is ready. The first beat of a sample passes the
// state register, then the output register; the 6-step gain divider runs under the clears.
// Synchronous active-low reset: phase hunt, column 0, gain 1, output empty.
`timescale 1ns / 1ps
`default_nettype none

module scope_trigger_trace_rasterizer_core #(
    parameter int TRACE_COLUMNS = 94
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sttr_pkg::GAIN_W-1:0] i_cfg_wr_data,
    sttr_sample_if.sink                 i_smp,
    sttr_write_if.source                o_wr
);
    import sttr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_smp.ready = w_in_ready;

    sttr_ctrl #(
        .TRACE_COLUMNS (TRACE_COLUMNS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_sample   (i_smp.sample),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sttr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (i_smp.sample),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_wr          (o_wr)
    );

endmodule

`default_nettype wire

// File: sv/sttr_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "scope_trigger_trace_rasterizer_core_assert.svh"

// Port-level checks on the rasterizer.
module sttr_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_chip_half,
    input logic [sttr_pkg::PAGE_W-1:0] i_page_row,
    input logic [sttr_pkg::ADDR_W-1:0] i_column_addr,
    input logic [sttr_pkg::BYTE_W-1:0] i_pixel_byte,
    input logic                        i_last_write
);
    logic w_stall;
    logic w_mid_take;

    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_mid_take = i_out_valid && i_out_ready && !i_last_write;

    // a stalled beat holds
    `STTR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(i_page_row) && $stable(i_pixel_byte) && $stable(i_column_addr) && $stable(i_chip_half) && $stable(i_last_write), "stalled write beat changed")

    // no new sample while a column is still being written
    `STTR_ASSERT_NOW(a_busy_no_take, i_clk, i_rst_n, i_out_valid && !i_last_write, !i_in_ready, "sample ready during an unfinished column")

    // every write of one sample goes to the same column
    `STTR_ASSERT_NEXT(a_same_col, i_clk, i_rst_n, w_mid_take, !i_out_valid || (i_column_addr == $past(i_column_addr) && i_chip_half == $past(i_chip_half)), "column changed within one sample")

endmodule

bind scope_trigger_trace_rasterizer_core sttr_chk u_sttr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_wr.valid),
    .i_out_ready   (o_wr.ready),
    .i_chip_half   (o_wr.chip_half),
    .i_page_row    (o_wr.page_row),
    .i_column_addr (o_wr.column_addr),
    .i_pixel_byte  (o_wr.pixel_byte),
    .i_last_write  (o_wr.last_write)
);

`default_nettype wire

// File: test/tb_scope_trigger_trace_rasterizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_scope_trigger_trace_rasterizer_core;
    import sttr_pkg::*;

    localparam int COLUMNS        = 94;
    localparam int MAX_GAP        = 6;
    localparam int SETTLE_CYCLES  = 32;   // well past the longest column of writes
    localparam int RX_HOLD_CYCLES = 200;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_SWEEP   = 2'd2
    } t_sweep_phase;

    typedef struct packed {
        logic              chip_half;
        logic [PAGE_W-1:0] page_row;
        logic [ADDR_W-1:0] column_addr;
        logic [BYTE_W-1:0] pixel_byte;
        logic              last_write;
    } t_lcd_write;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [GAIN_W-1:0] i_cfg_wr_data;

    sttr_sample_if smp_if ();
    sttr_write_if  wr_if ();

    scope_trigger_trace_rasterizer_core #(
        .TRACE_COLUMNS(COLUMNS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_smp         (smp_if),
        .o_wr          (wr_if)
    );

    // Clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Trace predictor state
    t_sweep_phase        trace_phase  = PH_HUNT;
    logic [SAMPLE_W-1:0] armed_level  = '0;
    logic [COL_W-1:0]    next_column  = '0;
    logic [PAGE_W-1:0]   last_page    = '0;
    logic [BYTE_W-1:0]   last_bit     = '0;
    logic [GAIN_W-1:0]   gain_setting = GAIN_RESET;
    t_lcd_write          expected_writes[$];

    // Stimulus side: samples waiting to be offered, plus a shadow of the trigger phase
    logic [SAMPLE_W-1:0] pending_samples[$];
    t_sweep_phase        gen_phase  = PH_HUNT;
    logic [SAMPLE_W-1:0] gen_armed  = '0;
    int                  gen_column = 0;
    int                  gen_prev   = 0;

    logic [SAMPLE_W-1:0] directed_samples[$] = '{
        8'd131, 8'd127, 8'd0, 8'd255,           // hunt noise
        8'd130, 8'd129,                         // arm, then a lower sample drops back to hunt
        8'd128, 8'd100,                         // arm, lower again
        8'd129, 8'd129,                         // arm, equal sample starts the sweep
        8'd255, 8'd0, 8'd255, 8'd250, 8'd245,   // jumps down and up, same bit, same page
        8'd210, 8'd240, 8'd220, 8'd128          // fills up and down within a page, then a page jump
    };

    // Handshake control
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    bit tx_busy;
    int tx_gap;
    int rx_stall;
    int rx_hold;
    int hold_requests = 0;
    int holds_served  = 0;

    int samples_taken  = 0;
    int writes_checked = 0;
    int sweeps_done    = 0;
    int mismatches     = 0;

    // Grow a byte toward bit 0 until the probe meets the stop bit
    function automatic logic [BYTE_W-1:0] smear_down(input logic [BYTE_W-1:0] pix,
                                                     input logic [BYTE_W-1:0] stop);
        logic [BYTE_W-1:0] probe;
        probe = pix >> 1;
        while (probe != stop && probe != '0) begin
            probe = probe >> 1;
            pix   = pix | (pix >> 1);
        end
        return pix;
    endfunction

    // Grow a byte toward bit 7 until the probe meets the stop bit
    function automatic logic [BYTE_W-1:0] smear_up(input logic [BYTE_W-1:0] pix,
                                                   input logic [BYTE_W-1:0] stop);
        logic [BYTE_W-1:0] probe;
        probe = pix << 1;
        while (probe != stop && probe != '0) begin
            probe = probe << 1;
            pix   = pix | (pix << 1);
        end
        return pix;
    endfunction

    task automatic expect_write(input logic chip, input logic [ADDR_W-1:0] addr,
                                input logic [PAGE_W-1:0] pg, input logic [BYTE_W-1:0] pix,
                                input logic last);
        t_lcd_write w;
        w.chip_half   = chip;
        w.page_row    = pg;
        w.column_addr = addr;
        w.pixel_byte  = pix;
        w.last_write  = last;
        expected_writes.push_back(w);
    endtask

    // One sweep column: page clears, then the point with its vertical fill
    task automatic render_column_writes(input logic [SAMPLE_W-1:0] s);
        logic              chip;
        logic [ADDR_W-1:0] addr;
        logic [PAGE_W-1:0] pg;
        logic [BYTE_W-1:0] bt;
        logic [BYTE_W-1:0] pix;
        int unsigned       div;
        int unsigned       lvl;
        int                row;
        chip = (next_column >= 64);
        addr = next_column[ADDR_W-1:0];
        for (int k = 0; k < 8; k++) begin
            expect_write(chip, addr, PAGE_W'(k), BYTE_CLEAR, 1'b0);
        end

        // gain of zero behaves as one
        div = (gain_setting == '0) ? 1 : gain_setting;
        lvl = (int'(s) * 196) / (1000 * div);
        if (lvl > 63) begin
            lvl = 63;
        end
        pg  = PAGE_W'(7 - lvl / 8);
        bt  = 8'h80 >> (lvl % 8);
        row = pg;
        pix = bt;

        if (next_column != '0) begin
            if (pg == last_page) begin
                if (pix > last_bit) begin
                    pix = smear_down(pix, last_bit);
                end else if (pix < last_bit) begin
                    pix = smear_up(pix, last_bit);
                end
            end else if (pg < last_page) begin
                // point above the last one: fill down through the pages between
                for (int k = 0; k < 7; k++) begin
                    pix = pix | (pix << 1);
                end
                expect_write(chip, addr, pg, pix, 1'b0);
                for (row = pg + 1; row < last_page; row++) begin
                    expect_write(chip, addr, PAGE_W'(row), BYTE_FULL, 1'b0);
                end
                pix = BYTE_BIT0;
                if (pix < last_bit) begin
                    pix = smear_up(pix, last_bit);
                end
            end else begin
                // point below the last one: fill upward
                for (int k = 0; k < 7; k++) begin
                    pix = pix | (pix >> 1);
                end
                expect_write(chip, addr, pg, pix, 1'b0);
                for (row = pg - 1; row > last_page; row--) begin
                    expect_write(chip, addr, PAGE_W'(row), BYTE_FULL, 1'b0);
                end
                pix = BYTE_BIT7;
                if (pix > last_bit) begin
                    pix = smear_down(pix, last_bit);
                end
            end
        end
        expect_write(chip, addr, PAGE_W'(row), pix, 1'b1);

        last_page = pg;
        last_bit  = bt;
        if (next_column + 1 >= COLUMNS) begin
            trace_phase = PH_HUNT;
            next_column = '0;
            sweeps_done++;
        end else begin
            next_column = COL_W'(next_column + 1);
        end
    endtask

    // Trigger phases plus rendering for one accepted sample
    task automatic predict_sample(input logic [SAMPLE_W-1:0] s);
        case (trace_phase)
            PH_CONFIRM: begin
                if (armed_level > s) begin
                    trace_phase = PH_HUNT;
                end else begin
                    trace_phase = PH_SWEEP;
                    next_column = '0;
                end
            end
            PH_SWEEP: begin
                render_column_writes(s);
            end
            default: begin
                trace_phase = PH_HUNT;
                if (s == TRIG_A || s == TRIG_B || s == TRIG_C) begin
                    armed_level = s;
                    trace_phase = PH_CONFIRM;
                end
            end
        endcase
    endtask

    // Queue a sample and track where the trigger will be once it is taken
    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        case (gen_phase)
            PH_CONFIRM: begin
                if (s < gen_armed) begin
                    gen_phase = PH_HUNT;
                end else begin
                    gen_phase  = PH_SWEEP;
                    gen_column = 0;
                end
            end
            PH_SWEEP: begin
                gen_prev = s;
                gen_column++;
                if (gen_column >= COLUMNS) begin
                    gen_phase = PH_HUNT;
                end
            end
            default: begin
                if (s == TRIG_A || s == TRIG_B || s == TRIG_C) begin
                    gen_armed = s;
                    gen_phase = PH_CONFIRM;
                end
            end
        endcase
    endtask

    // Mostly clean trigger sequences, some noise and failed confirms
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case (gen_phase)
            PH_CONFIRM: begin
                if ($urandom_range(0, 9) < 2 && gen_armed > 0) begin
                    v = $urandom_range(0, gen_armed - 1);
                end else begin
                    v = $urandom_range(gen_armed, 255);
                end
            end
            PH_SWEEP: begin
                case ($urandom_range(0, 9))
                    0: v = 0;
                    1: v = 255;
                    2, 3, 4, 5: v = $urandom_range(0, 255);
                    default: begin
                        // small steps keep neighbours on or near the same page
                        v = gen_prev + int'($urandom_range(0, 40)) - 20;
                        if (v < 0) begin
                            v = 0;
                        end else if (v > 255) begin
                            v = 255;
                        end
                    end
                endcase
            end
            default: begin
                if ($urandom_range(0, 4) == 0) begin
                    v = $urandom_range(0, 255);
                end else begin
                    v = TRIG_A + int'($urandom_range(0, 2));
                end
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            queue_sample(pick_sample());
        end
    endtask

    // Sender has nothing left, every write is back, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || smp_if.valid || expected_writes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gain_setting = g;
        @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want_v,
                                 input logic [BYTE_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch on write %0d: expected %0h, actual %0h",
                     $time, name, writes_checked, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_write(input t_lcd_write got);
        t_lcd_write want;
        if (expected_writes.size() == 0) begin
            $display({"%0t: unexpected write: expected none, ",
                      "actual chip %0d page %0d col %0d byte %02h last %0d"},
                     $time, got.chip_half, got.page_row, got.column_addr, got.pixel_byte,
                     got.last_write);
            mismatches++;
        end else begin
            want = expected_writes.pop_front();
            compare_field("chip_half", BYTE_W'(want.chip_half), BYTE_W'(got.chip_half));
            compare_field("page_row", BYTE_W'(want.page_row), BYTE_W'(got.page_row));
            compare_field("column_addr", BYTE_W'(want.column_addr),
                          BYTE_W'(got.column_addr));
            compare_field("pixel_byte", want.pixel_byte, got.pixel_byte);
            compare_field("last_write", BYTE_W'(want.last_write), BYTE_W'(got.last_write));
            writes_checked++;
        end
    endtask

    // Sample driver: predicts on every accepted beat, random gap before the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid  <= 1'b0;
            smp_if.sample <= '0;
            tx_gap = 0;
        end else begin
            tx_busy = smp_if.valid && !smp_if.ready;
            if (smp_if.valid && smp_if.ready) begin
                predict_sample(smp_if.sample);
                samples_taken++;
                tx_gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    smp_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    smp_if.valid  <= 1'b1;
                    smp_if.sample <= pending_samples.pop_front();
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // Write monitor: checks each beat, random stall after it, long hold on request
    always @(posedge i_clk) begin
        t_lcd_write got;
        if (!i_rst_n) begin
            wr_if.ready <= 1'b0;
            rx_stall = 0;
            rx_hold  = 0;
        end else begin
            if (wr_if.valid && wr_if.ready) begin
                got.chip_half   = wr_if.chip_half;
                got.page_row    = wr_if.page_row;
                got.column_addr = wr_if.column_addr;
                got.pixel_byte  = wr_if.pixel_byte;
                got.last_write  = wr_if.last_write;
                check_write(got);
                rx_stall = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                rx_hold = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                wr_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                wr_if.ready <= 1'b0;
            end else begin
                wr_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus sequence
    initial begin
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        wr_if.ready   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset gain: directed corner cases, then random sweeps
        foreach (directed_samples[i]) begin
            queue_sample(directed_samples[i]);
        end
        run_random(40);
        wait_drained();

        // largest gain flattens the trace
        write_gain(8'd255);
        run_random(40);
        wait_drained();

        // zero gain; sender streams while the receiver holds off
        write_gain(8'd0);
        tx_gaps_on = 1'b0;
        hold_requests++;
        run_random(50);
        wait_drained();

        // no idling on either side
        write_gain(8'd2);
        rx_gaps_on = 1'b0;
        run_random(50);
        wait_drained();

        // sender pauses mid-stream until all writes are back
        write_gain(8'd3);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_random(25);
        wait_drained();
        run_random(25);
        wait_drained();

        write_gain(GAIN_W'($urandom_range(4, 254)));
        run_random(30);
        wait_drained();

        write_gain(GAIN_MIN);
        run_random(40);
        wait_drained();

        $display("Run covered %0d samples and %0d LCD writes, %0d complete sweeps,",
                 samples_taken, writes_checked, sweeps_done);
        $display("gains 0, 1, 2, 3, 255 and one random, with stalls and a long output hold.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: scope_trigger_trace_rasterizer_core.f
+incdir+sv
sv/sttr_pkg.sv
sv/sttr_channels_if.sv
sv/sttr_div.sv
sv/sttr_ctrl.sv
sv/sttr_dp.sv
sv/scope_trigger_trace_rasterizer_core.sv
sv/sttr_chk.sv
test/tb_scope_trigger_trace_rasterizer_core.sv
